FILE: design/ple_pkg.sv
`timescale 1ns / 1ps
package ple_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ELEM_W      = 32;
    localparam int POS_W       = 7;
    localparam int CNT_W       = 7;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        MD_INS_END   = 3'd0,
        MD_INS_START = 3'd1,
        MD_INS_POS   = 3'd2,
        MD_DEL_START = 3'd3,
        MD_DEL_END   = 3'd4,
        MD_DEL_POS   = 3'd5,
        MD_READ      = 3'd6
    } mode_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] val;
        logic [IDX_W-1:0]       link;
    } node_t;

    // free-stack command from the sequencer
    typedef struct packed {
        logic             pop;
        logic             push;
        logic [IDX_W-1:0] push_idx;
    } fs_req_t;

    // free-stack status back to the sequencer
    typedef struct packed {
        logic [CNT_W-1:0] top;
        logic [IDX_W-1:0] pop_idx;
    } fs_stat_t;

    function automatic logic [VALUE_WIDTH-1:0] to_store(input logic signed [ELEM_W-1:0] v);
        return VALUE_WIDTH'(v);
    endfunction

    function automatic logic [ELEM_W-1:0] to_element(input logic [VALUE_WIDTH-1:0] s);
        logic signed [VALUE_WIDTH-1:0] ss;
        ss = s;
        return ELEM_W'(ss);
    endfunction

endpackage

FILE: design/ple_ram.sv
`timescale 1ns / 1ps
module ple_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/ple_free_stack.sv
`timescale 1ns / 1ps
module ple_free_stack
    import ple_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  fs_req_t  req,
    output fs_stat_t stat
);

    logic [CNT_W-1:0]    top_reg, top_next;
    logic [CAPACITY-1:0] vld_reg, vld_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic [IDX_W-1:0]    pop_addr;
    logic [IDX_W-1:0]    rdata;

    // an entry never pushed pops as its own index
    assign pop_addr = IDX_W'(top_reg - CNT_W'(1));

    ple_ram #(
        .WIDTH(IDX_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (req.push),
        .waddr(top_reg[IDX_W-1:0]),
        .wdata(req.push_idx),
        .re   (req.pop),
        .raddr(pop_addr),
        .rdata(rdata)
    );

    always_comb
    begin
        top_next  = top_reg;
        vld_next  = vld_reg;
        hit_next  = hit_reg;
        addr_next = addr_reg;
        if (req.pop)
        begin
            top_next  = top_reg - CNT_W'(1);
            hit_next  = vld_reg[pop_addr];
            addr_next = pop_addr;
        end
        else if (req.push)
        begin
            top_next                    = top_reg + CNT_W'(1);
            vld_next[top_reg[IDX_W-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= CNT_W'(CAPACITY);
            vld_reg  <= '0;
            hit_reg  <= 1'b0;
            addr_reg <= '0;
        end
        else
        begin
            top_reg  <= top_next;
            vld_reg  <= vld_next;
            hit_reg  <= hit_next;
            addr_reg <= addr_next;
        end
    end

    assign stat.top     = top_reg;
    assign stat.pop_idx = hit_reg ? rdata : addr_reg;

endmodule

FILE: design/positional_list_engine_core.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// cmd     | in        | cmd_valid / cmd_ready | mode[2:0], value[31:0], position[6:0]
// rsp     | out       | rsp_valid / rsp_ready | status[1:0], element[31:0], last, length[6:0]
//
// One command at a time. Inserts and deletes at position p above 1 walk p-2 links, one
// node RAM read per cycle; head operations skip the walk, and readout of n elements
// gives n beats. The node RAM read port sets that walk rate.
// Reset: list empty, all nodes on the free stack; no clearing pass is needed.
// A stalled rsp beat holds readout and the final result; the next command may be
// taken while the last beat of the previous one still waits in the output register.
module positional_list_engine_core
    import ple_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  logic [2:0]               mode,
    input  logic signed [ELEM_W-1:0] value,
    input  logic [POS_W-1:0]         position,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output logic [1:0]               status,
    output logic signed [ELEM_W-1:0] element,
    output logic                     last,
    output logic [CNT_W-1:0]         length
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_WR_HEAD,
        S_WALK,
        S_WR_NEW,
        S_WR_PREV,
        S_DEL_HEAD,
        S_DEL_FETCH,
        S_READ,
        S_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    mode_t                   mode_reg, mode_next;
    logic [ELEM_W-1:0]       val_reg, val_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    status_t                 res_reg, res_next;
    logic [CNT_W-1:0]        p_reg, p_next;        // effective 1-based position
    logic [CNT_W-1:0]        steps_reg, steps_next; // links left, or beats left in readout
    logic [IDX_W-1:0]        cur_reg, cur_next;
    logic                    started_reg, started_next;
    logic [IDX_W-1:0]        n_reg, n_next;        // new node, or victim on delete
    logic [VALUE_WIDTH-1:0]  pval_reg, pval_next;
    logic [IDX_W-1:0]        plink_reg, plink_next;

    logic                    rsp_valid_reg, rsp_valid_next;
    status_t                 status_reg, status_next;
    logic [ELEM_W-1:0]       element_reg, element_next;
    logic                    last_reg, last_next;
    logic [CNT_W-1:0]        length_reg, length_next;

    // node RAM port
    logic                    nm_we, nm_re;
    logic [IDX_W-1:0]        nm_waddr, nm_raddr;
    node_t                   nm_wdata, nm_rdata;

    fs_req_t                 fs_req;
    fs_stat_t                fs_stat;

    logic                    out_free;
    logic [CNT_W:0]          cnt_plus1;
    logic [CNT_W:0]          ins_p, del_p;
    logic                    is_insert;

    ple_ram #(
        .WIDTH($bits(node_t)),
        .DEPTH(CAPACITY)
    ) u_node_ram (
        .clk  (clk),
        .we   (nm_we),
        .waddr(nm_waddr),
        .wdata(nm_wdata),
        .re   (nm_re),
        .raddr(nm_raddr),
        .rdata(nm_rdata)
    );

    ple_free_stack u_free (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (fs_req),
        .stat (fs_stat)
    );

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign cnt_plus1 = {1'b0, count_reg} + (CNT_W+1)'(1);
    assign is_insert = (mode_reg == MD_INS_END) || (mode_reg == MD_INS_START)
                    || (mode_reg == MD_INS_POS);

    always_comb
    begin
        unique case (mode_reg)
            MD_INS_END:   ins_p = cnt_plus1;
            MD_INS_START: ins_p = (CNT_W+1)'(1);
            default:      ins_p = {1'b0, pos_reg};
        endcase
        unique case (mode_reg)
            MD_DEL_START: del_p = (CNT_W+1)'(1);
            MD_DEL_END:   del_p = {1'b0, count_reg};
            default:      del_p = {1'b0, pos_reg};
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        val_next     = val_reg;
        pos_next     = pos_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        res_next     = res_reg;
        p_next       = p_reg;
        steps_next   = steps_reg;
        cur_next     = cur_reg;
        started_next = started_reg;
        n_next       = n_reg;
        pval_next    = pval_reg;
        plink_next   = plink_reg;

        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        status_next    = status_reg;
        element_next   = element_reg;
        last_next      = last_reg;
        length_next    = length_reg;

        nm_we    = 1'b0;
        nm_waddr = n_reg;
        nm_wdata = '{val: to_store(val_reg), link: head_reg};
        nm_re    = 1'b0;
        nm_raddr = cur_reg;

        fs_req = '{pop: 1'b0, push: 1'b0, push_idx: n_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    mode_next  = mode_t'(mode);
                    val_next   = value;
                    pos_next   = position;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_next     = ST_OK;
                cur_next     = head_reg;
                started_next = 1'b0;
                priority case (1'b1)
                    is_insert:
                    begin
                        p_next     = CNT_W'(ins_p);
                        steps_next = CNT_W'(ins_p - (CNT_W+1)'(2));
                        // full check ahead of the position check
                        if (count_reg >= CNT_W'(CAPACITY) || fs_stat.top == '0)
                        begin
                            res_next   = ST_FULL;
                            state_next = S_EMIT;
                        end
                        else if (ins_p == '0 || ins_p > cnt_plus1)
                        begin
                            res_next   = ST_RANGE;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            fs_req.pop = 1'b1;
                            state_next = S_POP;
                        end
                    end
                    (mode_reg == MD_DEL_START) || (mode_reg == MD_DEL_END)
                        || (mode_reg == MD_DEL_POS):
                    begin
                        steps_next = CNT_W'(del_p - (CNT_W+1)'(2));
                        // empty check ahead of the position check
                        if (count_reg == '0)
                        begin
                            res_next   = ST_EMPTY;
                            state_next = S_EMIT;
                        end
                        else if (del_p == '0 || del_p > {1'b0, count_reg})
                        begin
                            res_next   = ST_RANGE;
                            state_next = S_EMIT;
                        end
                        else if (del_p == (CNT_W+1)'(1))
                        begin
                            nm_re      = 1'b1;
                            nm_raddr   = head_reg;
                            state_next = S_DEL_HEAD;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    mode_reg == MD_READ:
                    begin
                        steps_next = count_reg;
                        if (count_reg == '0)
                        begin
                            res_next   = ST_EMPTY;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        // unused mode: plain ok result
                        state_next = S_EMIT;
                    end
                endcase
            end

            S_POP:
            begin
                n_next = fs_stat.pop_idx;
                if (p_reg == CNT_W'(1))
                begin
                    state_next = S_WR_HEAD;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end

            S_WR_HEAD:
            begin
                nm_we      = 1'b1;
                nm_waddr   = n_reg;
                nm_wdata   = '{val: to_store(val_reg), link: head_reg};
                head_next  = n_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_EMIT;
            end

            S_WALK:
            begin
                // read data always belongs to cur_reg once started
                if (!started_reg)
                begin
                    nm_re        = 1'b1;
                    nm_raddr     = cur_reg;
                    started_next = 1'b1;
                end
                else if (steps_reg != '0)
                begin
                    nm_re      = 1'b1;
                    nm_raddr   = nm_rdata.link;
                    cur_next   = nm_rdata.link;
                    steps_next = steps_reg - CNT_W'(1);
                end
                else
                begin
                    pval_next  = nm_rdata.val;
                    plink_next = nm_rdata.link;
                    if (is_insert)
                    begin
                        state_next = S_WR_NEW;
                    end
                    else
                    begin
                        n_next     = nm_rdata.link;
                        nm_re      = 1'b1;
                        nm_raddr   = nm_rdata.link;
                        state_next = S_DEL_FETCH;
                    end
                end
            end

            S_WR_NEW:
            begin
                nm_we      = 1'b1;
                nm_waddr   = n_reg;
                nm_wdata   = '{val: to_store(val_reg), link: plink_reg};
                state_next = S_WR_PREV;
            end

            S_WR_PREV:
            begin
                nm_we      = 1'b1;
                nm_waddr   = cur_reg;
                nm_wdata   = '{val: pval_reg, link: n_reg};
                count_next = count_reg + CNT_W'(1);
                state_next = S_EMIT;
            end

            S_DEL_HEAD:
            begin
                head_next       = nm_rdata.link;
                fs_req.push     = 1'b1;
                fs_req.push_idx = head_reg;
                count_next      = count_reg - CNT_W'(1);
                state_next      = S_EMIT;
            end

            S_DEL_FETCH:
            begin
                // unlink victim: prev takes the victim's link
                nm_we           = 1'b1;
                nm_waddr        = cur_reg;
                nm_wdata        = '{val: pval_reg, link: nm_rdata.link};
                fs_req.push     = 1'b1;
                fs_req.push_idx = n_reg;
                count_next      = count_reg - CNT_W'(1);
                state_next      = S_EMIT;
            end

            S_READ:
            begin
                if (!started_reg)
                begin
                    nm_re        = 1'b1;
                    nm_raddr     = cur_reg;
                    started_next = 1'b1;
                end
                else if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = ST_OK;
                    element_next   = to_element(nm_rdata.val);
                    last_next      = (steps_reg == CNT_W'(1));
                    length_next    = count_reg;
                    if (steps_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        nm_re      = 1'b1;
                        nm_raddr   = nm_rdata.link;
                        steps_next = steps_reg - CNT_W'(1);
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = res_reg;
                    element_next   = '0;
                    last_next      = 1'b1;
                    length_next    = count_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MD_INS_END;
            val_reg       <= '0;
            pos_reg       <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            res_reg       <= ST_OK;
            p_reg         <= '0;
            steps_reg     <= '0;
            cur_reg       <= '0;
            started_reg   <= 1'b0;
            n_reg         <= '0;
            pval_reg      <= '0;
            plink_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            element_reg   <= '0;
            last_reg      <= 1'b0;
            length_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            val_reg       <= val_next;
            pos_reg       <= pos_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            res_reg       <= res_next;
            p_reg         <= p_next;
            steps_reg     <= steps_next;
            cur_reg       <= cur_next;
            started_reg   <= started_next;
            n_reg         <= n_next;
            pval_reg      <= pval_next;
            plink_reg     <= plink_next;
            rsp_valid_reg <= rsp_valid_next;
            status_reg    <= status_next;
            element_reg   <= element_next;
            last_reg      <= last_next;
            length_reg    <= length_next;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign element   = element_reg;
    assign last      = last_reg;
    assign length    = length_reg;

    // every node is either on the list or on the free stack; an insert pops its
    // node in S_DECODE, the count moves in S_WR_HEAD or S_WR_PREV; check between commands
    a_node_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_EMIT) |->
        (({1'b0, count_reg} + {1'b0, fs_stat.top}) == (CNT_W+1)'(CAPACITY)))
        else $error("list count and free stack depth disagree");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_FULL) |-> (length == CNT_W'(CAPACITY)))
        else $error("full status with free nodes left");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_EMPTY) |-> (length == '0 && last))
        else $error("empty status on a nonempty list");

    // the next readout beat may already sit in the output register
    a_read_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready && !last) |=> (state_reg == S_READ || rsp_valid))
        else $error("readout stopped before its last beat");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Bench for the positional list engine. Commands go in on the cmd channel and
// come back as one or more rsp beats. The expected beats come from a
// queue-based model of the list that tracks element order and count only.
module tb_top
    import ple_pkg::*;
();

    // mode 7 has no command; the engine answers it with a plain ok beat
    localparam logic [2:0] MD_NOP = 3'd7;

    localparam int RAND_ITEMS   = 295;
    localparam int STALL_LIMIT  = 4000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 100;   // quiet tail after the last owed beat
    localparam int MAX_REPORTS  = 10;

    // one expected rsp beat
    typedef struct packed {
        logic [1:0]               st;
        logic signed [ELEM_W-1:0] elem;
        logic                     is_last;
        logic [CNT_W-1:0]         len;
    } list_rsp_t;

    // directed row; when 'typed' is set the beat is given in the row itself
    typedef struct packed {
        logic [2:0]               md;
        logic signed [ELEM_W-1:0] val;
        logic [POS_W-1:0]         pos;
        logic                     typed;
        logic [1:0]               st;
        logic [CNT_W-1:0]         len;
    } dir_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cmd_valid = 1'b0;
    logic                     cmd_ready;
    logic [2:0]               mode = MD_INS_END;
    logic signed [ELEM_W-1:0] value = '0;
    logic [POS_W-1:0]         position = '0;
    logic                     rsp_valid;
    logic                     rsp_ready = 1'b0;
    logic [1:0]               status;
    logic signed [ELEM_W-1:0] element;
    logic                     last;
    logic [CNT_W-1:0]         length;

    // model state: list contents in order, and the beats still owed by the engine
    logic [VALUE_WIDTH-1:0] list_vals[$];
    list_rsp_t              pending_rsp[$];
    int                     mismatches = 0;
    bit                     calm = 1'b0;     // no idling on either side while set

    // Directed part. The list contents are noted after each row that changes it but the last delete, which empties it.
    dir_row_t dir_rows [25] = '{
        '{MD_READ,      32'sd0,          7'd0,   1'b1, ST_EMPTY, 7'd0},
        '{MD_DEL_START, 32'sd0,          7'd0,   1'b1, ST_EMPTY, 7'd0},
        '{MD_DEL_END,   32'sd0,          7'd0,   1'b1, ST_EMPTY, 7'd0},
        // empty wins over a bad position
        '{MD_DEL_POS,   32'sd0,          7'd0,   1'b1, ST_EMPTY, 7'd0},
        '{MD_INS_POS,   32'sd5,          7'd0,   1'b1, ST_RANGE, 7'd0},
        '{MD_INS_POS,   32'sd5,          7'd2,   1'b1, ST_RANGE, 7'd0},
        '{MD_INS_POS,   32'h7FFF_FFFF,   7'd1,   1'b1, ST_OK,    7'd1},  // max
        '{MD_INS_END,   32'h8000_0000,   7'd0,   1'b1, ST_OK,    7'd2},  // max min
        '{MD_INS_START, -32'sd1,         7'd127, 1'b1, ST_OK,    7'd3},  // -1 max min
        // position count+1 appends: -1 max min 0
        '{MD_INS_POS,   32'sd0,          7'd4,   1'b1, ST_OK,    7'd4},
        '{MD_INS_POS,   32'sd9,          7'd127, 1'b1, ST_RANGE, 7'd4},
        '{MD_INS_POS,   32'h5A5A_A5A5,   7'd3,   1'b1, ST_OK,    7'd5},  // -1 max X min 0
        '{MD_READ,      32'sd0,          7'd0,   1'b0, ST_OK,    7'd0},
        '{MD_DEL_POS,   32'sd0,          7'd0,   1'b1, ST_RANGE, 7'd5},
        '{MD_DEL_POS,   32'sd0,          7'd6,   1'b1, ST_RANGE, 7'd5},
        '{MD_DEL_POS,   32'sd0,          7'd127, 1'b1, ST_RANGE, 7'd5},
        '{MD_DEL_POS,   32'sd0,          7'd5,   1'b1, ST_OK,    7'd4},  // -1 max X min
        '{MD_DEL_POS,   32'sd0,          7'd2,   1'b1, ST_OK,    7'd3},  // -1 X min
        '{MD_NOP,       32'sd7,          7'd3,   1'b1, ST_OK,    7'd3},
        '{MD_READ,      32'sd0,          7'd0,   1'b0, ST_OK,    7'd0},
        '{MD_DEL_END,   32'sd0,          7'd0,   1'b1, ST_OK,    7'd2},  // -1 X
        '{MD_DEL_START, 32'sd0,          7'd0,   1'b1, ST_OK,    7'd1},  // X
        '{MD_DEL_POS,   32'sd0,          7'd1,   1'b1, ST_OK,    7'd0},
        '{MD_READ,      32'sd0,          7'd0,   1'b1, ST_EMPTY, 7'd0},
        '{MD_NOP,       -32'sd1,         7'd127, 1'b1, ST_OK,    7'd0}
    };

    positional_list_engine_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .mode      (mode),
        .value     (value),
        .position  (position),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .element   (element),
        .last      (last),
        .length    (length)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one command to the list model. With 'record' set, the beats it
    // causes are queued as expectations; otherwise only the list is updated.
    function automatic void apply_list_cmd(input logic [2:0] m,
                                           input logic signed [ELEM_W-1:0] v,
                                           input logic [POS_W-1:0] p,
                                           input bit record);
        int                           cnt;
        int                           tgt;
        logic [1:0]                   st;
        logic [VALUE_WIDTH-1:0]       stored;
        logic signed [VALUE_WIDTH-1:0] narrow;
        logic signed [ELEM_W-1:0]     wide;
        cnt = list_vals.size();
        st  = ST_OK;
        case (m)
            MD_INS_END, MD_INS_START, MD_INS_POS:
            begin
                tgt = (m == MD_INS_END) ? cnt + 1 : (m == MD_INS_START) ? 1 : int'(p);
                // full is checked ahead of the position
                if (cnt >= CAPACITY)
                    st = ST_FULL;
                else if (tgt < 1 || tgt > cnt + 1)
                    st = ST_RANGE;
                else
                begin
                    stored = v;
                    list_vals.insert(tgt - 1, stored);
                end
            end
            MD_DEL_START, MD_DEL_END, MD_DEL_POS:
            begin
                tgt = (m == MD_DEL_START) ? 1 : (m == MD_DEL_END) ? cnt : int'(p);
                // empty is checked ahead of the position
                if (cnt == 0)
                    st = ST_EMPTY;
                else if (tgt < 1 || tgt > cnt)
                    st = ST_RANGE;
                else
                    list_vals.delete(tgt - 1);
            end
            MD_READ:
            begin
                if (cnt == 0)
                    st = ST_EMPTY;
                else
                begin
                    // one beat per element, sign-extended from the stored width
                    for (int k = 0; k < cnt; k++)
                    begin
                        narrow = list_vals[k];
                        wide   = narrow;
                        if (record)
                            pending_rsp.push_back('{ST_OK, wide, k == cnt - 1, CNT_W'(cnt)});
                    end
                    return;
                end
            end
            default: ;
        endcase
        if (record)
            pending_rsp.push_back('{st, '0, 1'b1, CNT_W'(list_vals.size())});
    endfunction

    // Present one command beat, hold it until taken, then update the model.
    task automatic issue_cmd(input logic [2:0] m, input logic signed [ELEM_W-1:0] v,
                             input logic [POS_W-1:0] p, input logic typed,
                             input logic [1:0] t_st, input logic [CNT_W-1:0] t_len);
        while (!calm && $urandom_range(99) < 11)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        mode      <= m;
        value     <= v;
        position  <= p;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        apply_list_cmd(m, v, p, !typed);
        if (typed)
            pending_rsp.push_back('{t_st, '0, 1'b1, t_len});
    endtask

    // Random insert or delete; positions are mostly legal, some out of range.
    task automatic random_list_op(input bit do_insert);
        int               cnt;
        logic [2:0]       m;
        logic [POS_W-1:0] p;
        cnt = list_vals.size();
        p   = POS_W'($urandom_range(127));
        if (do_insert)
        begin
            m = 3'($urandom_range(MD_INS_POS, MD_INS_END));
            if (m == MD_INS_POS)
            begin
                if ($urandom_range(99) < 85)
                    p = POS_W'($urandom_range(cnt + 1, 1));
                else
                    p = POS_W'($urandom_range(1) ? 0 : $urandom_range(127, cnt + 2));
            end
        end
        else
        begin
            m = 3'($urandom_range(MD_DEL_POS, MD_DEL_START));
            if (m == MD_DEL_POS && cnt > 0)
            begin
                if ($urandom_range(99) < 85)
                    p = POS_W'($urandom_range(cnt, 1));
                else
                    p = POS_W'($urandom_range(1) ? 0 : $urandom_range(127, cnt + 1));
            end
        end
        issue_cmd(m, $urandom(), p, 1'b0, ST_OK, '0);
    endtask

    // rsp side: check every accepted beat against the oldest expectation,
    // then pick the ready level for the next cycle.
    always @(posedge clk)
    begin : rsp_check
        list_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected rsp beat: st=%0d el=%0d last=%0d len=%0d",
                             status, element, last, length);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (status !== want.st || element !== want.elem ||
                    last !== want.is_last || length !== want.len)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("rsp mismatch: exp st=%0d el=%0d last=%0d len=%0d,",
                                 want.st, want.elem, want.is_last, want.len,
                                 " got st=%0d el=%0d last=%0d len=%0d",
                                 status, element, last, length);
                end
            end
        end
        rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
    end

    // Watchdog: ends the run if neither channel moves a beat for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial
    begin : stimulus
        bit growing;
        bit probed_full;
        int roll;
        growing     = 1'b1;
        probed_full = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
            issue_cmd(dir_rows[r].md, dir_rows[r].val, dir_rows[r].pos,
                      dir_rows[r].typed, dir_rows[r].st, dir_rows[r].len);

        // Random part: the list drifts toward full, then toward empty, and so on,
        // so both walls and long walks are reached with random contents.
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            calm = (i >= 160 && i < 240);

            // hold off new commands until the engine has answered everything
            if (i == 120)
            begin
                cmd_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_rsp.size() != 0);
            end

            if (list_vals.size() == CAPACITY)
                growing = 1'b0;
            else if (list_vals.size() == 0)
                growing = 1'b1;

            // first time full: every insert kind is refused, bad positions too,
            // then the whole store is read out
            if (list_vals.size() == CAPACITY && !probed_full)
            begin
                probed_full = 1'b1;
                issue_cmd(MD_INS_END,   $urandom(), 7'd0,   1'b0, ST_OK, '0);
                issue_cmd(MD_INS_START, $urandom(), 7'd1,   1'b0, ST_OK, '0);
                issue_cmd(MD_INS_POS,   $urandom(), 7'd0,   1'b0, ST_OK, '0);
                issue_cmd(MD_INS_POS,   $urandom(), 7'd127, 1'b0, ST_OK, '0);
                issue_cmd(MD_INS_POS,   $urandom(), 7'd65,  1'b0, ST_OK, '0);
                issue_cmd(MD_READ,      $urandom(), 7'd0,   1'b0, ST_OK, '0);
            end

            roll = $urandom_range(99);
            if (roll < 8)
                issue_cmd(MD_READ, $urandom(), POS_W'($urandom_range(127)),
                          1'b0, ST_OK, '0);
            else if (roll < 12)
                // noise: any mode including the unused code, any position
                issue_cmd(3'($urandom_range(7)), $urandom(), POS_W'($urandom_range(127)),
                          1'b0, ST_OK, '0);
            else if (roll < 82)
                random_list_op(growing);
            else
                random_list_op(!growing);
        end

        // drain: every owed beat, then a quiet tail to catch stray beats
        calm = 1'b0;
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/ple_pkg.sv
design/ple_ram.sv
design/ple_free_stack.sv
design/positional_list_engine_core.sv
bench/tb_top.sv
